@@ src/tlbl_pkg.sv @@
// tlbl_pkg: request, result, scan and write types shared by the lfu tlb
// cells and the top level; no dependencies
`timescale 1ns / 1ps

package tlbl_pkg;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_ADD    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] page;
        logic [15:0] frame;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] found_frame;
    } res_t;

    // what travels from cell to cell along the chain
    typedef struct packed {
        logic        active;
        req_t        req;
        logic        found;
        logic [15:0] found_frame;
    } scan_t;

    // entry write, broadcast to every cell
    typedef struct packed {
        logic        en;
        logic [15:0] page;
        logic [15:0] frame;
    } wr_t;

endpackage

@@ src/tlb_lfu_replacement_top.sv @@
// tlb_lfu_replacement_top: fully associative tlb with lfu replacement
// depends on tlbl_pkg and tlbl_cell
`timescale 1ns / 1ps

// Fully associative TLB of ENTRIES entries with least-frequently-used
// replacement. A request is taken when start is high and busy is low; each
// request gives exactly one result, shown on result for one cycle with done
// high. The receiver cannot stall: sample result whenever done is high.
// done rises and busy drops on the same edge, so requests never overlap: with
// start held high a new one is taken only once the last has answered. Each
// request passes the launch register and then the scan chain: each entry sits in
// its own cell, and the request walks the row one cell per clock. On its
// way a lookup claims the first valid matching entry (that cell bumps its
// saturating use count in place) and the running minimum count with its
// index is handed along for replacement. When the walk ends, an add is
// written into the next free slot, or once the table is full into the
// lowest-indexed entry with the smallest count, with a count of 1. A lookup
// answers hit plus frame, a miss or an add answers zeros. Adding a page
// that is already present makes a second entry; lookups see the first one.

module tlb_lfu_replacement_top #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tlbl_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output tlbl_pkg::res_t result
);
    import tlbl_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    // chain links: element i feeds cell i, element ENTRIES is the chain end
    scan_t                 scan_chain [ENTRIES+1];
    logic                  ok_chain   [ENTRIES+1];
    logic [COUNT_BITS-1:0] cnt_chain  [ENTRIES+1];
    logic [IDX_W-1:0]      idx_chain  [ENTRIES+1];

    logic                  busy_reg, busy_next;
    scan_t                 launch_reg, launch_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic                  done_reg, done_next;
    res_t                  result_reg, result_next;

    logic                  accept;
    logic                  table_full;
    scan_t                 chain_end;
    wr_t                   wr;
    logic [IDX_W-1:0]      wr_idx;

    assign accept     = start && !busy_reg;
    assign table_full = (fill_reg == FILL_W'(ENTRIES));
    assign chain_end  = scan_chain[ENTRIES];

    // head of the chain: no minimum found yet
    assign scan_chain[0] = launch_reg;
    assign ok_chain[0]   = 1'b0;
    assign cnt_chain[0]  = '0;
    assign idx_chain[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            tlbl_cell #(
                .COUNT_BITS (COUNT_BITS),
                .IDX_W      (IDX_W),
                .CELL_IDX   (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .scan_in      (scan_chain[gi]),
                .best_ok_in   (ok_chain[gi]),
                .best_cnt_in  (cnt_chain[gi]),
                .best_idx_in  (idx_chain[gi]),
                .scan_out     (scan_chain[gi+1]),
                .best_ok_out  (ok_chain[gi+1]),
                .best_cnt_out (cnt_chain[gi+1]),
                .best_idx_out (idx_chain[gi+1]),
                .wr           (wr),
                .wr_idx       (wr_idx)
            );
        end
    endgenerate

    always_comb
    begin
        // an add is written once the walk reaches the chain end
        wr.en    = chain_end.active && (chain_end.req.action == ACT_ADD);
        wr.page  = chain_end.req.page;
        wr.frame = chain_end.req.frame;
        // victim when full, otherwise the next free slot
        wr_idx   = table_full ? idx_chain[ENTRIES] : fill_reg[IDX_W-1:0];

        fill_next = fill_reg;
        if (wr.en && !table_full)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end

        launch_next             = '0;
        launch_next.active      = accept;
        launch_next.req         = request;

        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (chain_end.active)
        begin
            busy_next = 1'b0;
        end

        done_next               = chain_end.active;
        result_next.hit         = chain_end.found;
        result_next.found_frame = chain_end.found ? chain_end.found_frame : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= '0;
            fill_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= launch_next;
            fill_reg   <= fill_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // a miss or an add never carries a frame
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.found_frame == 16'd0))
        else $error("result frame nonzero without hit");

    // an accepted request holds off the next one
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after request");

    // the result appears only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // fill level never passes the table size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(ENTRIES))
        else $error("fill level beyond table size");

endmodule

@@ src/tlbl_cell.sv @@
// tlbl_cell: one tlb entry with its use count, one link of the scan chain
// depends on tlbl_pkg
`timescale 1ns / 1ps

module tlbl_cell #(
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4,
    parameter int CELL_IDX   = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlbl_pkg::scan_t       scan_in,
    input  logic                  best_ok_in,
    input  logic [COUNT_BITS-1:0] best_cnt_in,
    input  logic [IDX_W-1:0]      best_idx_in,
    output tlbl_pkg::scan_t       scan_out,
    output logic                  best_ok_out,
    output logic [COUNT_BITS-1:0] best_cnt_out,
    output logic [IDX_W-1:0]      best_idx_out,
    input  tlbl_pkg::wr_t         wr,
    input  logic [IDX_W-1:0]      wr_idx
);
    import tlbl_pkg::*;

    logic                  valid_reg, valid_next;
    logic [15:0]           page_reg, page_next;
    logic [15:0]           frame_reg, frame_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    scan_t                 scan_reg, scan_next;
    logic                  best_ok_reg, best_ok_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;

    logic hit_here;
    logic take;
    logic wr_here;

    always_comb
    begin
        hit_here = scan_in.active && (scan_in.req.action == ACT_LOOKUP) &&
                   !scan_in.found && valid_reg && (page_reg == scan_in.req.page);
        // strict less-than keeps the lowest index on ties
        take     = valid_reg && (!best_ok_in || (cnt_reg < best_cnt_in));
        wr_here  = wr.en && (wr_idx == IDX_W'(CELL_IDX));

        valid_next = valid_reg;
        page_next  = page_reg;
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        if (wr_here)
        begin
            valid_next = 1'b1;
            page_next  = wr.page;
            frame_next = wr.frame;
            cnt_next   = COUNT_BITS'(1);
        end
        else if (hit_here && (cnt_reg != {COUNT_BITS{1'b1}}))
        begin
            cnt_next = cnt_reg + COUNT_BITS'(1);
        end

        scan_next = scan_in;
        if (hit_here)
        begin
            scan_next.found       = 1'b1;
            scan_next.found_frame = frame_reg;
        end

        if (take)
        begin
            best_ok_next  = 1'b1;
            best_cnt_next = cnt_reg;
            best_idx_next = IDX_W'(CELL_IDX);
        end
        else
        begin
            best_ok_next  = best_ok_in;
            best_cnt_next = best_cnt_in;
            best_idx_next = best_idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            scan_reg    <= '0;
            best_ok_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            scan_reg    <= scan_next;
            best_ok_reg <= best_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        frame_reg    <= frame_next;
        cnt_reg      <= cnt_next;
        best_cnt_reg <= best_cnt_next;
        best_idx_reg <= best_idx_next;
    end

    assign scan_out     = scan_reg;
    assign best_ok_out  = best_ok_reg;
    assign best_cnt_out = best_cnt_reg;
    assign best_idx_out = best_idx_reg;

endmodule

@@ test/tlb_lfu_replacement_top_tb.sv @@
// tlb_lfu_replacement_top_tb: self-checking bench for the lfu tlb, with an
// in-bench shadow of the table that predicts every answer
// depends on tlbl_pkg and tlb_lfu_replacement_top
`timescale 1ns / 1ps

module tlb_lfu_replacement_top_tb;

    import tlbl_pkg::*;

    // narrow use counts so saturation is reached in a short run
    localparam int SLOTS       = 16;
    localparam int CNT_W       = 4;
    localparam int POOL        = 24;
    localparam int QUIET_LIMIT = 4000;

    // shadow of the table: predicts each answer and checks it on arrival
    class tlb_ledger;
        localparam int N  = SLOTS;
        localparam int CW = CNT_W;

        bit [15:0]   page_tab[N];
        bit [15:0]   frame_tab[N];
        bit [CW-1:0] use_tab[N];
        int unsigned filled;
        res_t        answers_due[$];
        int unsigned mismatches;

        function new();
            filled     = 0;
            mismatches = 0;
            foreach (page_tab[i])
            begin
                page_tab[i]  = '0;
                frame_tab[i] = '0;
                use_tab[i]   = '0;
            end
        endfunction

        // update the shadow for an accepted request and queue its answer
        function void note_request(req_t r);
            res_t        ans;
            bit          found;
            int unsigned victim;
            ans   = '0;
            found = 1'b0;
            if (r.action == ACT_LOOKUP)
            begin
                // slots fill in order, so slot i is live exactly when i < filled
                for (int i = 0; i < N; i++)
                begin
                    if (!found && i < filled && page_tab[i] == r.page)
                    begin
                        found = 1'b1;
                        if (use_tab[i] != {CW{1'b1}})
                            use_tab[i] = use_tab[i] + 1'b1;
                        ans.hit         = 1'b1;
                        ans.found_frame = frame_tab[i];
                    end
                end
            end
            else
            begin
                if (filled < N)
                begin
                    victim = filled;
                    filled++;
                end
                else
                begin
                    // lowest index wins among equal smallest counts
                    victim = 0;
                    for (int i = 1; i < N; i++)
                        if (use_tab[i] < use_tab[victim])
                            victim = i;
                end
                page_tab[victim]  = r.page;
                frame_tab[victim] = r.frame;
                use_tab[victim]   = 1;
            end
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns mismatch %s: got %h want %h", $time, what, got_v, want_v);
        endtask

        task check_result(res_t got);
            res_t want;
            if (answers_due.size() == 0)
            begin
                report_mismatch("answer with no request outstanding", got.found_frame, 16'h0);
            end
            else
            begin
                want = answers_due.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", 16'(got.hit), 16'(want.hit));
                if (got.found_frame !== want.found_frame)
                    report_mismatch("found_frame", got.found_frame, want.found_frame);
            end
        endtask

        function int unsigned outstanding();
            return answers_due.size();
        endfunction
    endclass

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    res_t result;

    tlb_ledger ledger = new();

    // pages reused often enough that lookups hit and counts climb
    bit [15:0]   page_pool[POOL];
    int unsigned quiet_cycles = 0;

    tlb_lfu_replacement_top #(
        .ENTRIES    (SLOTS),
        .COUNT_BITS (CNT_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // answers last one cycle and cannot be held off, so take every one
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_result(result);
    end

    // watchdog: cycles with neither a request taken nor an answer seen
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic req_t mk_req(logic act, logic [15:0] pg, logic [15:0] fr);
        req_t r;
        r.action = act;
        r.page   = pg;
        r.frame  = fr;
        return r;
    endfunction

    // optional idle gap, then hold start until the request is taken;
    // start is left high so back-to-back requests need no extra edge
    task automatic issue(input req_t r, input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.note_request(r);
    endtask

    // drop start and wait until every queued answer has come back
    task automatic drain_answers();
        start <= 1'b0;
        @(posedge clk);
        while (ledger.outstanding() != 0)
            @(posedge clk);
    endtask

    // extremes kept in the pool, the rest redrawn
    task automatic refresh_pool();
        page_pool[0] = 16'h0000;
        page_pool[1] = 16'hffff;
        for (int i = 2; i < POOL; i++)
            page_pool[i] = 16'($urandom);
    endtask

    // random traffic: mostly pool pages so the table fills, hits and evicts,
    // a few stray pages for misses; idle_pct is the chance of a gap per request
    task automatic run_phase(input int unsigned idle_pct, input int unsigned n);
        req_t        r;
        int unsigned gap;
        for (int unsigned k = 0; k < n; k++)
        begin
            r.action = ($urandom_range(0, 99) < 30) ? ACT_ADD : ACT_LOOKUP;
            if ($urandom_range(0, 99) < 88)
                r.page = page_pool[$urandom_range(0, POOL - 1)];
            else
                r.page = 16'($urandom);
            case ($urandom_range(0, 9))
                0:       r.frame = 16'h0000;
                1:       r.frame = 16'hffff;
                default: r.frame = 16'($urandom);
            endcase
            // random idle gaps between requests, drawn only when idle_pct allows
            gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 24) : 0;
            // now and then let the block run completely dry
            if ($urandom_range(0, 199) == 0)
                drain_answers();
            issue(r, gap);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicate add, saturation
        issue(mk_req(ACT_LOOKUP, 16'h0000, 16'hffff), 0);  // miss on empty table
        issue(mk_req(ACT_ADD,    16'h0000, 16'hffff), 0);  // add answers zeros
        issue(mk_req(ACT_ADD,    16'hffff, 16'h0000), 0);
        issue(mk_req(ACT_ADD,    16'h0000, 16'h1234), 0);  // duplicate page
        issue(mk_req(ACT_LOOKUP, 16'h0000, 16'h5a5a), 0);  // first copy answers
        issue(mk_req(ACT_LOOKUP, 16'h8001, 16'h0000), 0);  // miss, partly filled
        // hammer one entry past the top of its use count
        for (int k = 0; k < 16; k++)
            issue(mk_req(ACT_LOOKUP, 16'hffff, 16'(k)), 0);
        drain_answers();

        // random phases: no idling, heavy idling, light idling, no idling;
        // each ends with a full drain
        refresh_pool();
        run_phase(0, 470);
        drain_answers();
        refresh_pool();
        run_phase(64, 470);
        drain_answers();
        refresh_pool();
        run_phase(25, 470);
        drain_answers();
        refresh_pool();
        run_phase(0, 470);
        drain_answers();

        // room for any stray answer after the last expected one
        repeat (SLOTS + 4) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
